// ===== design/relative_vigor_index_macros.svh =====
// assertion macros of the relative vigor index checker
`ifndef RELATIVE_VIGOR_INDEX_MACROS_SVH
`define RELATIVE_VIGOR_INDEX_MACROS_SVH

// concurrent assertion, quiet while reset is high
`define RVI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also watches the reset cycles
`define RVI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rvi_pkg.sv =====
// shared constants, types and control structs of the relative vigor index
package rvi_pkg;

  // fixed field widths of the stream and config ports
  localparam int FIELD_BITS    = 24;
  localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
  localparam int WIN_BITS      = 9;
  localparam int BARS_BITS     = 10;
  localparam int RATIO_BITS    = 18;
  localparam int OUT_DATA_BITS = 24;

  // defaults of the top level parameters
  localparam int DEFAULT_MAX_WINDOW = 256;
  localparam int DEFAULT_PRICE_BITS = 24;

  // window length after reset
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(10);

  // q1.16 scale and the divider length (17 fraction bits, then rounded)
  localparam int Q_ONE      = 65536;
  localparam int QUO_BITS   = 17;
  localparam int DIV_STEPS  = QUO_BITS;
  localparam int STEP_BITS  = 5;

  // bars needed before the first weighted term
  localparam int WARMUP_BARS = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic calc;
    logic sum;
    logic prep;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== design/rvi_datapath.sv =====
// datapath: bar history, term ring, window sums, serial divider, output register
module rvi_datapath #(
  parameter int MAX_WINDOW = rvi_pkg::DEFAULT_MAX_WINDOW,
  parameter int PRICE_BITS = rvi_pkg::DEFAULT_PRICE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rvi_pkg::cmd_t                     cmd,
  output rvi_pkg::status_t                  status,
  input  logic [rvi_pkg::IN_DATA_BITS-1:0]  in_data,
  input  logic                              cfg_write,
  input  logic [rvi_pkg::WIN_BITS-1:0]      cfg_window,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [rvi_pkg::RATIO_BITS-1:0] out_ratio,
  output logic                              out_forced
);
  import rvi_pkg::*;

  localparam int PB = (PRICE_BITS < FIELD_BITS) ? PRICE_BITS : FIELD_BITS;
  localparam int DW = PB + 1;                       // body and range
  localparam int TW = PB + 4;                       // 1-2-2-1 weighted term
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = TW + AW;                      // window sum
  localparam int XW = ((AW > WIN_BITS) ? AW : WIN_BITS) + 1;

  // configuration and history
  logic [WIN_BITS-1:0]   window_length;
  logic [WIN_BITS-1:0]   eff_window;
  logic signed [DW-1:0]  recent_bodies [3];
  logic signed [DW-1:0]  recent_ranges [3];
  logic signed [DW-1:0]  body_in;
  logic signed [DW-1:0]  range_in;
  logic signed [TW-1:0]  body_term;
  logic signed [TW-1:0]  range_term;
  logic signed [SW-1:0]  body_sum;
  logic signed [SW-1:0]  range_sum;
  logic [AW-1:0]         ring_pointer;
  logic [BARS_BITS-1:0]  bars_seen;
  logic [BARS_BITS-1:0]  bars_limit;
  logic                  have_terms;
  logic                  drop_old;

  // term ring
  logic [2*TW-1:0]       term_ring [MAX_WINDOW];
  logic [2*TW-1:0]       ring_rdata;
  logic [XW-1:0]         old_diff;
  logic [AW-1:0]         old_addr;

  // divider
  logic                  ratio_neg;
  logic                  ratio_sat;
  logic                  ratio_forced;
  logic [SW-1:0]         divisor;
  logic [SW-1:0]         remainder;
  logic [SW:0]           rem_shift;
  logic [QUO_BITS-1:0]   quotient;
  logic [SW-1:0]         body_mag;
  logic [RATIO_BITS-1:0] q_round;
  logic signed [RATIO_BITS-1:0] ratio_value;

  logic [PB-1:0] open_p, high_p, low_p, close_p;

  // low price bits of each field
  assign open_p  = in_data[0*FIELD_BITS +: PB];
  assign high_p  = in_data[1*FIELD_BITS +: PB];
  assign low_p   = in_data[2*FIELD_BITS +: PB];
  assign close_p = in_data[3*FIELD_BITS +: PB];

  // effective window: zero reads as one, clamp to ring depth
  always_comb begin
    if (window_length == '0) begin
      eff_window = WIN_BITS'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      eff_window = WIN_BITS'(MAX_WINDOW);
    end else begin
      eff_window = window_length;
    end
  end

  assign bars_limit = BARS_BITS'(eff_window) + BARS_BITS'(WARMUP_BARS);

  // ring slot of the term that leaves the window
  always_comb begin
    old_diff = XW'(ring_pointer) - XW'(eff_window);
    if (old_diff[XW-1]) begin
      old_diff = old_diff + XW'(MAX_WINDOW);
    end
    old_addr = old_diff[AW-1:0];
  end

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_write) begin
      window_length <= cfg_window;
    end
  end

  // bar request capture: body and range
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      body_in  <= $signed({1'b0, close_p}) - $signed({1'b0, open_p});
      range_in <= $signed({1'b0, high_p}) - $signed({1'b0, low_p});
    end
  end

  // weighted terms and flags, registered
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      body_term  <= TW'(body_in) + (TW'(recent_bodies[0]) <<< 1)
                  + (TW'(recent_bodies[1]) <<< 1) + TW'(recent_bodies[2]);
      range_term <= TW'(range_in) + (TW'(recent_ranges[0]) <<< 1)
                  + (TW'(recent_ranges[1]) <<< 1) + TW'(recent_ranges[2]);
      have_terms <= (bars_seen >= BARS_BITS'(WARMUP_BARS));
      drop_old   <= (bars_seen >= bars_limit);
    end
  end

  // history shift, bar count, window sums and ring pointer
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      for (int i = 0; i < 3; i++) begin
        recent_bodies[i] <= '0;
        recent_ranges[i] <= '0;
      end
      bars_seen    <= '0;
      body_sum     <= '0;
      range_sum    <= '0;
      ring_pointer <= '0;
    end else begin
      if (cmd.calc) begin
        recent_bodies[2] <= recent_bodies[1];
        recent_bodies[1] <= recent_bodies[0];
        recent_bodies[0] <= body_in;
        recent_ranges[2] <= recent_ranges[1];
        recent_ranges[1] <= recent_ranges[0];
        recent_ranges[0] <= range_in;
        if (bars_seen < bars_limit) begin
          bars_seen <= bars_seen + BARS_BITS'(1);
        end
      end
      if (cmd.sum && have_terms) begin
        body_sum  <= SW'(SW'(body_sum) + SW'(body_term)
                   - (drop_old ? SW'($signed(ring_rdata[TW-1:0])) : SW'(0)));
        range_sum <= SW'(SW'(range_sum) + SW'(range_term)
                   - (drop_old ? SW'($signed(ring_rdata[2*TW-1:TW])) : SW'(0)));
        if (32'(ring_pointer) == MAX_WINDOW - 1) begin
          ring_pointer <= '0;
        end else begin
          ring_pointer <= ring_pointer + AW'(1);
        end
      end
    end
  end

  // term ring memory: read the leaving term, write the new one
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ring_rdata <= term_ring[old_addr];
    end
    if (cmd.sum && have_terms) begin
      term_ring[ring_pointer] <= {range_term, body_term};
    end
  end

  assign body_mag = body_sum[SW-1] ? SW'(-body_sum) : SW'(body_sum);

  // divider setup and restoring steps
  assign rem_shift = {remainder, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ratio_forced <= !have_terms || range_sum[SW-1] || (range_sum == '0);
      ratio_neg    <= body_sum[SW-1];
      ratio_sat    <= (body_mag >= SW'(range_sum));
      divisor      <= SW'(range_sum);
      remainder    <= body_mag;
      quotient     <= '0;
    end else if (cmd.div_step) begin
      if (rem_shift >= {1'b0, divisor}) begin
        remainder <= SW'(rem_shift - {1'b0, divisor});
        quotient  <= {quotient[QUO_BITS-2:0], 1'b1};
      end else begin
        remainder <= rem_shift[SW-1:0];
        quotient  <= {quotient[QUO_BITS-2:0], 1'b0};
      end
    end
  end

  // round half up from the extra fraction bit, saturate, apply sign
  always_comb begin
    q_round = (RATIO_BITS'(quotient) + RATIO_BITS'(1)) >> 1;
    if (ratio_sat) begin
      q_round = RATIO_BITS'(Q_ONE);
    end
    if (ratio_forced) begin
      ratio_value = '0;
    end else if (ratio_neg) begin
      ratio_value = -$signed(q_round);
    end else begin
      ratio_value = $signed(q_round);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ratio  <= ratio_value;
      out_forced <= ratio_forced;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== design/rvi_controller.sv =====
// controller: sequences one bar through terms, sums, divider and output
module rvi_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rvi_pkg::status_t status,
  output rvi_pkg::cmd_t    cmd
);
  import rvi_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step_count;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (rst || state == ST_PREP) begin
      step_count <= '0;
    end else if (state == ST_DIV) begin
      step_count <= step_count + STEP_BITS'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CALC;
      ST_CALC:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_PREP;
      ST_PREP:   state_next = ST_DIV;
      ST_DIV:    if (step_count == STEP_BITS'(DIV_STEPS - 1)) state_next = ST_FINISH;
      ST_FINISH: if (!status.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CALC:   cmd.calc     = 1'b1;
      ST_SUM:    cmd.sum      = 1'b1;
      ST_PREP:   cmd.prep     = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_FINISH: cmd.load_out = !status.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/relative_vigor_index.sv =====
// relative vigor index over a stream of price bars
//
// s_axis carries one bar per request: open, high, low, close price ticks.
// m_axis returns one result per bar: the ratio of the windowed 1-2-2-1
// weighted bodies to the weighted ranges in signed q1.16 on tdata, and on
// tuser a flag that is set when the ratio was forced to zero (fewer than
// four bars, or range sum not positive).
// cfg writes the window length; a write also clears the bar history.
// after a bar request is taken, the block forms the weighted terms, updates
// the window sums, sets up the divider, runs the restoring divider at one
// quotient bit per cycle and loads the output register. a new bar is taken
// only once that result is loaded: only one bar is in flight at a time.
// the finished result sits in an output register, so a stalled receiver
// holds the block only when the next result is ready to load.
// reset sets the window length to 10, empties the history and the output
// register; the term ring needs no clearing pass.
module relative_vigor_index #(
  parameter int MAX_WINDOW = rvi_pkg::DEFAULT_MAX_WINDOW,
  parameter int PRICE_BITS = rvi_pkg::DEFAULT_PRICE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // open_price, high_price, low_price, close_price
  input  logic [rvi_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // vigor_ratio, zero fill
  output logic [rvi_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // forced_zero
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rvi_pkg::WIN_BITS-1:0]       cfg_data
);
  import rvi_pkg::*;

  cmd_t                         cmd;
  status_t                      status;
  logic signed [RATIO_BITS-1:0] ratio;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  rvi_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rvi_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_data    (s_axis_tdata),
    .cfg_write  (cfg_valid),
    .cfg_window (cfg_data),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ratio  (ratio),
    .out_forced (m_axis_tuser)
  );

  // result packing
  assign m_axis_tdata = {{(OUT_DATA_BITS - RATIO_BITS){1'b0}}, ratio};

endmodule

// ===== design/rvi_checker.sv =====
// port-level checker of the relative vigor index and its bind
`include "relative_vigor_index_macros.svh"

module rvi_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rvi_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                              m_axis_tuser
);

  // a stalled result holds its value
  `RVI_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

  // one bar at a time: no request right after one was taken
  `RVI_ASSERT(a_one_in_flight, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "bar taken while busy")

  // a forced result carries zero
  `RVI_ASSERT(a_forced_zero, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "forced result not zero")

  // ratio stays within plus or minus one, fill bits clear
  `RVI_ASSERT(a_ratio_range, clk, rst, m_axis_tvalid |-> ((m_axis_tdata <= 24'h010000) || ((m_axis_tdata >= 24'h030000) && (m_axis_tdata <= 24'h03FFFF))), "ratio out of range")

  // reset empties the output register
  `RVI_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind relative_vigor_index rvi_checker u_rvi_checker (.*);

// ===== tb/relative_vigor_index_tb.sv =====
// self-checking testbench for the relative vigor index block
`timescale 1ns / 1ps

module relative_vigor_index_tb;
  import rvi_pkg::*;

  localparam int WINDOW_MAX    = DEFAULT_MAX_WINDOW;
  localparam int PRICE_MAX     = (1 << FIELD_BITS) - 1;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [FIELD_BITS-1:0] price_t;

  // one expected output request
  typedef struct packed {
    logic signed [RATIO_BITS-1:0] ratio;
    logic                         forced;
  } vigor_result_t;

  // predicts the ratio for every accepted bar and checks the results in order
  class vigor_scoreboard;
    logic [WIN_BITS-1:0] window_length;
    longint              last_body[3];
    longint              last_span[3];
    longint              body_terms[WINDOW_MAX];
    longint              span_terms[WINDOW_MAX];
    longint              body_total;
    longint              span_total;
    int unsigned         slot;
    int unsigned         bar_count;
    vigor_result_t       expected_q[$];
    int                  errors;
    int                  checked;
    int                  forced_seen;
    int                  saturated_seen;

    function new();
      window_length = WINDOW_RESET;
      foreach (body_terms[i]) begin
        body_terms[i] = 0;
        span_terms[i] = 0;
      end
      errors = 0;
      checked = 0;
      forced_seen = 0;
      saturated_seen = 0;
      forget_history();
    endfunction

    function void forget_history();
      foreach (last_body[i]) begin
        last_body[i] = 0;
        last_span[i] = 0;
      end
      body_total = 0;
      span_total = 0;
      slot = 0;
      bar_count = 0;
    endfunction

    function void set_window(logic [WIN_BITS-1:0] value);
      window_length = value;
      forget_history();
    endfunction

    function int unsigned active_window();
      if (window_length == 0) return 1;
      if (window_length > WINDOW_MAX) return WINDOW_MAX;
      return window_length;
    endfunction

    // num / den in q1.16, round half away from zero, clipped to +-1
    function longint q16_ratio(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      if (mag >= den) q = Q_ONE;
      else q = (mag * 2 * Q_ONE + den) / (2 * den);
      return (num < 0) ? -q : q;
    endfunction

    function void note_bar(price_t o, price_t h, price_t l, price_t c);
      longint        op_v, hi_v, lo_v, cl_v;
      longint        body, span, body_term, span_term, q;
      int unsigned   w, oldest;
      vigor_result_t res;
      op_v = o;
      hi_v = h;
      lo_v = l;
      cl_v = c;
      body = cl_v - op_v;
      span = hi_v - lo_v;
      w = active_window();
      res.ratio = '0;
      res.forced = 1'b1;

      // weighted terms only once three earlier bars are known
      if (bar_count >= WARMUP_BARS) begin
        body_term = body + 2 * last_body[0] + 2 * last_body[1] + last_body[2];
        span_term = span + 2 * last_span[0] + 2 * last_span[1] + last_span[2];
        body_total += body_term;
        span_total += span_term;
        if (bar_count - 2 > w) begin
          oldest = (slot + WINDOW_MAX - w) % WINDOW_MAX;
          body_total -= body_terms[oldest];
          span_total -= span_terms[oldest];
        end
        body_terms[slot] = body_term;
        span_terms[slot] = span_term;
        slot = (slot + 1) % WINDOW_MAX;
        if (span_total > 0) begin
          q = q16_ratio(body_total, span_total);
          res.ratio = q[RATIO_BITS-1:0];
          res.forced = 1'b0;
        end
      end

      last_body[2] = last_body[1];
      last_body[1] = last_body[0];
      last_body[0] = body;
      last_span[2] = last_span[1];
      last_span[1] = last_span[0];
      last_span[0] = span;
      if (bar_count < w + WARMUP_BARS) bar_count++;
      if (bar_count > w + WARMUP_BARS) bar_count = w + WARMUP_BARS;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_BITS-1:0] data, logic flag);
      vigor_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no bar pending: tdata %h tuser %b", data, flag);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.forced) forced_seen++;
      if (!want.forced && (want.ratio == Q_ONE || want.ratio == -Q_ONE)) saturated_seen++;
      if (data[RATIO_BITS-1:0] !== want.ratio) begin
        $error("vigor_ratio: expected %0d, got %0d", want.ratio,
               $signed(data[RATIO_BITS-1:0]));
        errors++;
      end
      if (flag !== want.forced) begin
        $error("forced_zero: expected %b, got %b", want.forced, flag);
        errors++;
      end
      if (data[OUT_DATA_BITS-1:RATIO_BITS] !== '0) begin
        $error("tdata fill: expected 0, got %h", data[OUT_DATA_BITS-1:RATIO_BITS]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [WIN_BITS-1:0]      cfg_data = '0;

  vigor_scoreboard sb = new();
  bit              no_idle = 1'b0;
  int              cycles = 0;
  int              windows_written = 0;

  relative_vigor_index i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // receiver side: random stall before each result request
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // one bar request; valid stays high when the next gap is zero
  task automatic send_bar(input price_t o, input price_t h, input price_t l, input price_t c);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c, l, h, o};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_bar(o, h, l, c);
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // window write once all results are out and the block has settled
  task automatic write_window(input logic [WIN_BITS-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_window(value);
    cfg_valid <= 1'b0;
    windows_written++;
  endtask

  // mostly plausible bars, some flat ones and some with unrelated fields
  task automatic send_random_bar();
    int unsigned kind, center, spread, lo, hi;
    price_t      o, h, l, c;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      o = price_t'($urandom);
      h = o;
      l = o;
      c = o;
    end else if (kind < 25) begin
      o = price_t'($urandom);
      h = price_t'($urandom);
      l = price_t'($urandom);
      c = price_t'($urandom);
    end else begin
      center = $urandom_range(0, PRICE_MAX);
      spread = $urandom_range(0, 1 << $urandom_range(0, 22));
      lo = (center > spread) ? center - spread : 0;
      hi = (PRICE_MAX - center > spread) ? center + spread : PRICE_MAX;
      o = price_t'($urandom_range(lo, hi));
      c = price_t'($urandom_range(lo, hi));
      h = price_t'(hi);
      l = price_t'(lo);
    end
    send_bar(o, h, l, c);
  endtask

  // a run of random bars, back to back between calm_from and calm_to
  task automatic run_bars(input int count, input int calm_from, input int calm_to);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= calm_from && i < calm_to);
      send_random_bar();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window: warm-up, extreme prices, inverted and flat ranges
    send_bar(0, 0, 0, 0);
    send_bar(price_t'(PRICE_MAX), price_t'(PRICE_MAX), price_t'(PRICE_MAX),
             price_t'(PRICE_MAX));
    send_bar(0, price_t'(PRICE_MAX), 0, price_t'(PRICE_MAX));
    send_bar(price_t'(PRICE_MAX), price_t'(PRICE_MAX), 0, 0);
    send_bar(5, 0, price_t'(PRICE_MAX), 7);
    send_bar(7, 0, price_t'(PRICE_MAX), 5);
    send_bar(100, 100, 100, 100);
    send_bar(1000, 1200, 900, 1100);

    // single term window: saturation both ways, negative and zero range
    write_window(1);
    repeat (4) send_bar(0, 10, 0, 1000);
    repeat (4) send_bar(1000, 10, 0, 0);
    repeat (2) send_bar(5, 0, 10, 5);
    repeat (2) send_bar(0, 0, 0, 0);

    // random phases over several window settings
    write_window(WIN_BITS'(WINDOW_MAX));
    run_bars(280, 100, 160);
    write_window(0);
    run_bars(30, 0, 0);
    write_window(511);
    run_bars(30, 10, 20);
    write_window(1);
    run_bars(40, 0, 0);
    write_window(WIN_BITS'($urandom_range(2, 40)));
    run_bars(40, 5, 15);
    write_window(WIN_BITS'($urandom_range(41, 255)));
    run_bars(30, 0, 0);

    // drain
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d bar results over %0d window writes", sb.checked, windows_written);
    $display("%0d results forced to zero, %0d clipped to +-1", sb.forced_seen,
             sb.saturated_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
